// ===== design/corx_pkg.sv =====
package corx_pkg;

    // Field widths shared by the core and the address stage.
    localparam int COORD_W = 16;
    localparam int ROW_W   = 14;
    localparam int COLOR_W = 32;
    localparam int ADDR_W  = 64;

    // Register select, taken from paddr bit 3 (registers sit 8 bytes apart).
    localparam logic REG_FB_BASE    = 1'b0;
    localparam logic REG_ROW_PIXELS = 1'b1;

    // Transaction kinds on the input channel.
    localparam logic KIND_START = 1'b0;
    localparam logic KIND_STEP  = 1'b1;

    localparam logic [ROW_W-1:0] ROW_PIXELS_RESET = 14'd1024;

    // One pixel write on its way to the address stage.
    typedef struct packed {
        logic [COORD_W-1:0] px;
        logic [COORD_W-1:0] py;
        logic [COLOR_W-1:0] colour;
        logic               last;
        logic               done;
    } t_pix;

endpackage

// ===== design/corx_addr_gen.sv =====
module corx_addr_gen
    import corx_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  t_pix              i_pix,
    input  logic [ADDR_W-1:0] i_fb_base,
    input  logic [ROW_W-1:0]  i_row_pixels,
    output logic              o_valid,
    input  logic              i_ready,
    output t_pix              o_pix,
    output logic [ADDR_W-1:0] o_byte_address
);

    // Stage B holds the pixel offset px + py * row_pixels, stage C the final address.
    logic        r_b_valid;
    t_pix        r_b_pix;
    logic [30:0] r_b_off;
    logic        r_c_valid;
    t_pix        r_c_pix;
    logic [ADDR_W-1:0] r_c_addr;

    logic        ready_c;
    logic        ready_b;
    logic [29:0] prod;

    assign ready_c = !r_c_valid || i_ready;
    assign ready_b = !r_b_valid || ready_c;
    assign o_ready = ready_b;
    assign prod    = i_pix.py * i_row_pixels;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            if (ready_b) begin
                r_b_valid <= i_valid;
            end
            if (ready_c) begin
                r_c_valid <= r_b_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready_b && i_valid) begin
            r_b_pix <= i_pix;
            r_b_off <= {1'b0, prod} + {15'd0, i_pix.px};
        end
        if (ready_c && r_b_valid) begin
            r_c_pix  <= r_b_pix;
            r_c_addr <= i_fb_base + {31'd0, r_b_off, 2'b00};
        end
    end

    assign o_valid        = r_c_valid;
    assign o_pix          = r_c_pix;
    assign o_byte_address = r_c_addr;

endmodule

// ===== design/circle_outline_rasterizer_core.sv =====
// Midpoint circle outline rasterizer producing framebuffer pixel writes.
//
// Input channel (i_valid / o_ready): a start transaction (kind 0) loads the
// center, radius and color and produces no output. Each step transaction
// (kind 1) produces four pixel-write transactions on the output channel
// (o_valid / i_ready), the fourth flagged by o_last_of_step, and the fourth of
// the final step also flagged by o_circle_done. A step with no circle in
// progress is taken and produces nothing.
// A step accepted into the step register passes through address stages B
// and C before its first write appears. Writes leave at one per cycle while
// the receiver does not stall; the four-slot step register feeds the single
// address multiplier. The next step is accepted in the cycle its predecessor's
// last write moves on, so steps flow back to back. When the receiver stalls,
// the two address stages fill, then the step register holds, and o_ready
// drops until room opens again. Synchronous active-low reset empties all
// stages, ends any circle and sets fb_base to 0 and row_pixels to 1024.
// The user must write registers over APB, at byte addresses 0 (fb_base) and
// 8 (row_pixels), only while the block is idle; the block does not enforce it.
module circle_outline_rasterizer_core
    import corx_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // Configuration port.
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [3:0]                paddr,
    input  logic [63:0]               pwdata,
    output logic [63:0]               prdata,
    output logic                      pready,
    // Input channel.
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic                      i_kind,
    input  logic signed [COORD_W-1:0] i_centre_x,
    input  logic signed [COORD_W-1:0] i_centre_y,
    input  logic [14:0]               i_radius,
    input  logic [COLOR_W-1:0]        i_colour,
    // Output channel.
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [COORD_W-1:0]        o_pixel_x,
    output logic [COORD_W-1:0]        o_pixel_y,
    output logic [ADDR_W-1:0]         o_byte_address,
    output logic [COLOR_W-1:0]        o_pixel_value,
    output logic                      o_last_of_step,
    output logic                      o_circle_done
);

    // Absolute value of an 18-bit signed coordinate, kept to 16 bits.
    function automatic logic [COORD_W-1:0] fold(input logic signed [17:0] v);
        logic [17:0] a;
        a = v[17] ? 18'(-v) : v;
        return a[COORD_W-1:0];
    endfunction

    // Configuration registers.
    logic [ADDR_W-1:0] r_fb_base;
    logic [ROW_W-1:0]  r_row_pixels;

    // Circle state.
    logic                      r_active;
    logic signed [COORD_W-1:0] r_cx;
    logic signed [COORD_W-1:0] r_cy;
    logic [COLOR_W-1:0]        r_colour;
    logic signed [16:0]        r_x;
    logic signed [16:0]        r_y;
    logic signed [19:0]        r_err;

    // Step register: the four folded pixels of one step, issued one per cycle while the address stage is ready.
    logic               r_a_valid;
    logic [1:0]         r_a_slot;
    logic [COORD_W-1:0] r_a_px [4];
    logic [COORD_W-1:0] r_a_py [4];
    logic [COLOR_W-1:0] r_a_colour;
    logic               r_a_done;

    logic               cfg_wr;
    logic               in_fire;
    logic               start_load;
    logic               step_load;
    logic               gen_ready;
    logic               gen_fire;
    logic               a_last;
    t_pix               gen_pix;
    t_pix               out_pix;

    logic signed [17:0] cx18, cy18, x18, y18;
    logic               e_gt_x, e_le_y;
    logic signed [16:0] n_x, n_y;
    logic signed [19:0] n_err;
    logic signed [19:0] inc_x, inc_y;
    logic               n_done;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        case (paddr[3])
            REG_FB_BASE:    prdata = r_fb_base;
            REG_ROW_PIXELS: prdata = {50'd0, r_row_pixels};
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fb_base    <= '0;
            r_row_pixels <= ROW_PIXELS_RESET;
        end else if (cfg_wr) begin
            case (paddr[3])
                REG_FB_BASE:    r_fb_base    <= pwdata;
                REG_ROW_PIXELS: r_row_pixels <= pwdata[ROW_W-1:0];
                default:        ;
            endcase
        end
    end

    // The step register is free when empty, or when its last pixel moves on now.
    assign a_last   = (r_a_slot == 2'd3);
    assign gen_fire = r_a_valid && gen_ready;
    assign o_ready  = !r_a_valid || (gen_ready && a_last);
    assign in_fire  = i_valid && o_ready;
    assign start_load = in_fire && (i_kind == KIND_START);
    assign step_load  = in_fire && (i_kind == KIND_STEP) && r_active;

    // Midpoint error update; both moves may happen in one step.
    assign cx18   = {{2{r_cx[15]}}, r_cx};
    assign cy18   = {{2{r_cy[15]}}, r_cy};
    assign x18    = {r_x[16], r_x};
    assign y18    = {r_y[16], r_y};
    assign e_gt_x = r_err >  $signed({{3{r_x[16]}}, r_x});
    assign e_le_y = r_err <= $signed({{3{r_y[16]}}, r_y});
    assign n_x    = e_gt_x ? r_x + 17'sd1 : r_x;
    assign n_y    = e_le_y ? r_y + 17'sd1 : r_y;
    assign inc_x  = e_gt_x ? {{2{n_x[16]}}, n_x, 1'b1} : 20'sd0;
    assign inc_y  = e_le_y ? {{2{n_y[16]}}, n_y, 1'b1} : 20'sd0;
    assign n_err  = r_err + inc_x + inc_y;
    assign n_done = !n_x[16];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else if (start_load) begin
            r_active <= 1'b1;
        end else if (step_load && n_done) begin
            r_active <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start_load) begin
            r_cx     <= i_centre_x;
            r_cy     <= i_centre_y;
            r_colour <= i_colour;
            r_x      <= 17'sd0 - $signed({2'b00, i_radius});
            r_y      <= 17'sd0;
            r_err    <= 20'sd2 - $signed({4'b0000, i_radius, 1'b0});
        end else if (step_load) begin
            r_x   <= n_x;
            r_y   <= n_y;
            r_err <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_a_slot  <= 2'd0;
        end else if (step_load) begin
            r_a_valid <= 1'b1;
            r_a_slot  <= 2'd0;
        end else if (gen_fire) begin
            r_a_slot <= r_a_slot + 2'd1;
            if (a_last) begin
                r_a_valid <= 1'b0;
            end
        end
    end

    // The four writes use the coordinates as they stood before the update.
    always_ff @(posedge i_clk) begin
        if (step_load) begin
            r_a_px[0]  <= fold(cx18 - x18);
            r_a_py[0]  <= fold(cy18 + y18);
            r_a_px[1]  <= fold(cx18 - y18);
            r_a_py[1]  <= fold(cy18 - x18);
            r_a_px[2]  <= fold(cx18 + x18);
            r_a_py[2]  <= fold(cy18 - y18);
            r_a_px[3]  <= fold(cx18 + y18);
            r_a_py[3]  <= fold(cy18 + x18);
            r_a_colour <= r_colour;
            r_a_done   <= n_done;
        end
    end

    always_comb begin
        gen_pix.px     = r_a_px[r_a_slot];
        gen_pix.py     = r_a_py[r_a_slot];
        gen_pix.colour = r_a_colour;
        gen_pix.last   = a_last;
        gen_pix.done   = a_last && r_a_done;
    end

    corx_addr_gen u_addr_gen (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (r_a_valid),
        .o_ready        (gen_ready),
        .i_pix          (gen_pix),
        .i_fb_base      (r_fb_base),
        .i_row_pixels   (r_row_pixels),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_pix          (out_pix),
        .o_byte_address (o_byte_address)
    );

    assign o_pixel_x      = out_pix.px;
    assign o_pixel_y      = out_pix.py;
    assign o_pixel_value  = out_pix.colour;
    assign o_last_of_step = out_pix.last;
    assign o_circle_done  = out_pix.done;

endmodule

// ===== design/corx_checker.sv =====
module corx_checker
    import corx_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_valid,
    input logic               i_ready,
    input logic [ADDR_W-1:0]  o_byte_address,
    input logic [COLOR_W-1:0] o_pixel_value,
    input logic               o_last_of_step,
    input logic               o_circle_done
);

    // A stalled write keeps its address.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_byte_address))
        else $error("output write changed while stalled");

    // The end of a circle falls on the last write of a step.
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_circle_done |-> o_last_of_step)
        else $error("circle end outside the last write of a step");

    // The writes of one step leave without a gap.
    a_step_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_last_of_step |=> o_valid)
        else $error("gap inside the writes of a step");

    // All writes of a step carry the same color.
    a_step_colour: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_last_of_step |=> o_pixel_value == $past(o_pixel_value))
        else $error("color changed inside a step");

endmodule

bind circle_outline_rasterizer_core corx_checker u_corx_checker (.*);
